// ===== hw/rtl/huffman_table_encoder_core_macros.svh =====
// Assertion macros for the table-driven Huffman encoder.
// Included by the top level; no other dependencies.
`ifndef HUFFMAN_TABLE_ENCODER_CORE_MACROS_SVH
`define HUFFMAN_TABLE_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication checked on every rising edge outside reset.
`define HTE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("huffman encoder: same-cycle check failed");
// Next-cycle implication checked on every rising edge outside reset.
`define HTE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("huffman encoder: next-cycle check failed");
`else
`define HTE_ASSERT_IMP(label, clk, rst, ante, cons)
`define HTE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/hte_pkg.sv =====
// Shared constants, operation codes and controller/datapath interface types
// for the table-driven Huffman encoder. No dependencies.
package hte_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int IN_DATA_W = 48;   // symbol + code_length + code_bits, padded to bytes
  localparam int BYTE_W = 8;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tbl_write;   // store the input word's code into the tables
    logic tbl_read;    // start a table lookup at the input word's symbol
    logic acc_load;    // merge the looked-up code with the pending bits
    logic emit_byte;   // move the top full byte of the accumulator to the output
    logic flush_emit;  // move the zero-padded pending bits to the output
  } hte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic in_range;    // input symbol is inside the table
    logic pend_nz;     // pending bit count is nonzero
    logic len_zero;    // looked-up entry is empty
    logic short_code;  // merged code leaves fewer than eight bits
    logic obuf_free;   // output register can take a word this cycle
    logic emit_final;  // the byte emitted now is the last one of the item
  } hte_status_t;

endpackage

// ===== hw/rtl/hte_ctrl.sv =====
// Controller state machine of the Huffman encoder: sequences lookup,
// byte emission and flush. Uses hte_pkg for command and status types.
module hte_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hte_pkg::hte_status_t status,
  output hte_pkg::hte_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (status.op)
            hte_pkg::OP_LOAD: begin
              cmd.tbl_write = status.in_range;
            end
            hte_pkg::OP_ENCODE: begin
              if (status.in_range) begin
                cmd.tbl_read = 1'b1;
                state_next   = ST_LOOK;
              end
            end
            hte_pkg::OP_FLUSH: begin
              if (status.pend_nz) state_next = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        state_next = ST_IDLE;
        if (!status.len_zero) begin
          cmd.acc_load = 1'b1;
          if (!status.short_code) state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.obuf_free) begin
          cmd.emit_byte = 1'b1;
          if (status.emit_final) state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.obuf_free) begin
          cmd.flush_emit = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/hte_dp.sv =====
// Datapath of the Huffman encoder: code tables, bit accumulator, pending bits
// and the output register. Uses hte_pkg; driven by hte_ctrl commands.
module hte_dp #(
  parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hte_pkg::OP_W-1:0]      operation,
  input  logic [hte_pkg::SYM_W-1:0]     symbol,
  input  logic [hte_pkg::LEN_W-1:0]     load_len,
  input  logic [hte_pkg::CODE_W-1:0]    code_bits,
  input  hte_pkg::hte_cmd_t             cmd,
  output hte_pkg::hte_status_t          status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hte_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last
);

  localparam int CAP   = (MAX_CODE_LEN > hte_pkg::CODE_W) ? hte_pkg::CODE_W : MAX_CODE_LEN;
  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ACC_W = CAP + 7;
  localparam int TOT_W = $clog2(ACC_W + 1);
  localparam int LEN_W = hte_pkg::LEN_W;

  // Tables: lengths read as zero until their entry is written.
  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [CAP-1:0]          bits_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_valid;

  logic [IDX_W-1:0] addr;
  logic [LEN_W-1:0] len_sat;
  logic [CAP-1:0]   code_mask;
  logic             rd_vld;
  logic [LEN_W-1:0] len_q;
  logic [CAP-1:0]   bits_q;
  logic [LEN_W-1:0] rd_len;

  logic [ACC_W-1:0] acc;
  logic [TOT_W-1:0] total;
  logic [6:0]       pending_bits;
  logic [2:0]       pending_count;

  logic [ACC_W-1:0] acc_new;
  logic [TOT_W-1:0] total_new;
  logic [TOT_W-1:0] total_rem;
  logic [ACC_W-1:0] acc_shifted;
  logic [6:0]       rem_mask;
  logic [14:0]      flush_wide;
  logic             obuf_free;

  assign addr    = symbol[IDX_W-1:0];
  assign len_sat = (load_len > LEN_W'(CAP)) ? LEN_W'(CAP) : load_len;

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      code_mask[i] = (LEN_W'(i) < len_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_write) begin
      len_mem[addr]  <= len_sat;
      bits_mem[addr] <= code_bits[CAP-1:0] & code_mask;
    end
    if (cmd.tbl_read) begin
      len_q  <= len_mem[addr];
      bits_q <= bits_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (cmd.tbl_write) len_valid[addr] <= 1'b1;
      if (cmd.tbl_read)  rd_vld <= len_valid[addr];
    end
  end

  assign rd_len = rd_vld ? len_q : '0;

  // The new code goes below the pending bits, first bit highest.
  assign acc_new     = (ACC_W'(pending_bits) << rd_len) | ACC_W'(bits_q);
  assign total_new   = TOT_W'(pending_count) + TOT_W'(rd_len);
  assign total_rem   = total - TOT_W'(8);
  assign acc_shifted = acc >> total_rem;
  assign rem_mask    = 7'((8'h1 << total_rem[2:0]) - 8'h1);
  assign flush_wide  = {8'h0, pending_bits} << (4'd8 - {1'b0, pending_count});

  assign obuf_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc   <= acc_new;
      total <= total_new;
    end else if (cmd.emit_byte) begin
      total <= total_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (cmd.acc_load && (total_new < TOT_W'(8))) begin
      pending_bits  <= acc_new[6:0];
      pending_count <= total_new[2:0];
    end else if (cmd.emit_byte && status.emit_final) begin
      pending_bits  <= acc[6:0] & rem_mask;
      pending_count <= total_rem[2:0];
    end else if (cmd.flush_emit) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end
  end

  // Output register: holds one word so input can be taken during a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_byte || cmd.flush_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_byte <= acc_shifted[7:0];
      out_last <= status.emit_final;
    end else if (cmd.flush_emit) begin
      out_byte <= flush_wide[7:0];
      out_last <= 1'b1;
    end
  end

  assign status.op         = operation;
  assign status.in_range   = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
  assign status.pend_nz    = (pending_count != 3'd0);
  assign status.len_zero   = (rd_len == '0);
  assign status.short_code = (total_new < TOT_W'(8));
  assign status.obuf_free  = obuf_free;
  assign status.emit_final = (total_rem < TOT_W'(8));

endmodule

// ===== hw/rtl/huffman_table_encoder_core.sv =====
// Table-driven Huffman encoder: top level joining controller and datapath.
// Depends on hte_pkg, hte_ctrl, hte_dp and huffman_table_encoder_core_macros.svh.
//
// Input stream (s_axis): tuser carries the operation, tdata the symbol, code
// length and code bits. A load word writes one symbol's code into the tables,
// an encode word appends its symbol's code to the bit accumulator, and a
// flush word pads the waiting bits with zeros and sends them as one byte.
// Output stream (m_axis): one packed byte per word, earliest bit in bit 7;
// tlast marks the final byte produced by an input word.
// Sequencing: load, unused and flush-with-nothing-waiting words need no state
// beyond idle. An encode word goes through a table read, then a merge into
// the accumulator, then emits the bytes it produces; a flush emits its one
// byte from the flush state. Bytes leave at most one per cycle through the
// single output register.
// Reset clears the per-entry valid bits of the length table, so every
// symbol reads as empty until loaded; no clearing pass is needed.
// When the receiver stalls, the output register holds its byte and the
// encoder waits before producing the next one; new input words are still
// taken while the last byte of the previous word waits.
`include "huffman_table_encoder_core_macros.svh"

module huffman_table_encoder_core #(
  parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // symbol [7:0], code length [13:8], code_bits [45:14], zero [47:46]
  input  logic [hte_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation [1:0]
  input  logic [hte_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_byte [7:0]
  output logic [hte_pkg::BYTE_W-1:0]       m_axis_tdata,
  output logic                             m_axis_tlast
);

  hte_pkg::hte_cmd_t    cmd;
  hte_pkg::hte_status_t status;
  logic                 lookup_start;

  hte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hte_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .operation   (s_axis_tuser),
    .symbol      (s_axis_tdata[7:0]),
    .load_len    (s_axis_tdata[13:8]),
    .code_bits   (s_axis_tdata[45:14]),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

  assign lookup_start = s_axis_tvalid && s_axis_tready &&
                        (status.op == hte_pkg::OP_ENCODE) && status.in_range;

  // A lookup in progress blocks the input for at least the next cycle.
  `HTE_ASSERT_NXT(a_lookup_blocks, clk, rst, lookup_start, !s_axis_tready)
  // A flush leaves no bits waiting.
  `HTE_ASSERT_NXT(a_flush_clears, clk, rst, cmd.flush_emit, !status.pend_nz)
  // After the final byte of an item the encoder is ready again.
  `HTE_ASSERT_NXT(a_final_returns, clk, rst, cmd.emit_byte && status.emit_final, s_axis_tready)
  // Bytes are only produced when the output register can take them.
  `HTE_ASSERT_IMP(a_emit_has_room, clk, rst, cmd.emit_byte || cmd.flush_emit, status.obuf_free)

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for huffman_table_encoder_core: loads code tables, encodes bytes,
// flushes, and compares every output byte with an in-bench bit-packing predictor.
// Depends on hte_pkg and the huffman_table_encoder_core RTL only.
`timescale 1ns / 100ps

module testbench;

  localparam logic [hte_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LEN_CAP = (hte_pkg::MAX_CODE_LEN_DEF < hte_pkg::CODE_W) ?
                           hte_pkg::MAX_CODE_LEN_DEF : hte_pkg::CODE_W;
  localparam int DIRECTED_N = 25;
  localparam int RANDOM_N = 320;

  typedef struct packed {
    logic [hte_pkg::BYTE_W-1:0] out_val;
    logic                       last;
  } packed_byte_t;

  // Predicts the packed byte stream and checks the bytes that leave the block.
  class huff_stream_scoreboard;
    bit [hte_pkg::LEN_W-1:0]  len_tbl [hte_pkg::SYMBOL_COUNT_DEF];
    bit [hte_pkg::CODE_W-1:0] code_tbl [hte_pkg::SYMBOL_COUNT_DEF];
    bit [6:0]                 pend_bits;
    bit [2:0]                 pend_cnt;
    packed_byte_t             byte_q [$];
    int                       errors;

    task flag_error(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    function int pending();
      return byte_q.size();
    endfunction

    function void note_word(logic [hte_pkg::OP_W-1:0] op, logic [hte_pkg::SYM_W-1:0] sym,
                            logic [hte_pkg::LEN_W-1:0] len,
                            logic [hte_pkg::CODE_W-1:0] bits);
      int unsigned l;
      int unsigned total;
      int unsigned nbytes;
      logic [hte_pkg::CODE_W-1:0] mask;
      logic [38:0] acc;
      logic [7:0] keep;
      packed_byte_t item;
      case (op)
        hte_pkg::OP_LOAD: begin
          l = (32'(len) > LEN_CAP) ? LEN_CAP : 32'(len);
          mask = (l >= hte_pkg::CODE_W) ? '1 : ((32'd1 << l) - 32'd1);
          len_tbl[sym] = l[hte_pkg::LEN_W-1:0];
          code_tbl[sym] = bits & mask;
        end
        hte_pkg::OP_ENCODE: begin
          l = 32'(len_tbl[sym]);
          if (l != 0) begin
            acc = ({32'd0, pend_bits} << l) | {7'd0, code_tbl[sym]};
            total = 32'(pend_cnt) + l;
            nbytes = total / 8;
            for (int k = 0; k < nbytes; k++) begin
              item.out_val = 8'(acc >> (total - 8 * (k + 1)));
              item.last = (k == nbytes - 1);
              byte_q = {byte_q, item};
            end
            total = total % 8;
            keep = (8'd1 << total) - 8'd1;
            pend_bits = acc[6:0] & keep[6:0];
            pend_cnt = total[2:0];
          end
        end
        hte_pkg::OP_FLUSH: begin
          if (pend_cnt != 0) begin
            item.out_val = {1'b0, pend_bits} << (8 - pend_cnt);
            item.last = 1'b1;
            byte_q = {byte_q, item};
            pend_bits = '0;
            pend_cnt = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task check_byte(logic [hte_pkg::BYTE_W-1:0] got_val, logic got_last);
      packed_byte_t want;
      if (byte_q.size() == 0) begin
        flag_error($sformatf("byte %02h with nothing expected", got_val));
      end else begin
        want = byte_q.pop_front();
        if (got_val !== want.out_val)
          flag_error($sformatf("byte %02h, expected %02h", got_val, want.out_val));
        if (got_last !== want.last)
          flag_error($sformatf("tlast %b on byte %02h, expected %b",
                               got_last, got_val, want.last));
      end
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [hte_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic [hte_pkg::OP_W-1:0]      s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [hte_pkg::BYTE_W-1:0]    m_axis_tdata;
  logic                          m_axis_tlast;

  huff_stream_scoreboard sb = new();
  bit quiet;
  int sink_hold = 0;
  logic [hte_pkg::SYM_W-1:0] hot_syms [$];

  huffman_table_encoder_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_byte(m_axis_tdata, m_axis_tlast);
    if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold <= quiet ? 0 : pick_gap();
    end
  end

  // Valid stays high between back-to-back words; it only drops for a gap.
  task automatic send_word(logic [hte_pkg::OP_W-1:0] op, logic [hte_pkg::SYM_W-1:0] sym,
                           logic [hte_pkg::LEN_W-1:0] len,
                           logic [hte_pkg::CODE_W-1:0] bits);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {2'b00, bits, len, sym};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(op, sym, len, bits);
  endtask

  task automatic send_random_word(int idx);
    int r;
    logic [hte_pkg::SYM_W-1:0] sym;
    logic [hte_pkg::LEN_W-1:0] len;
    r = $urandom_range(0, 99);
    sym = 8'($urandom_range(0, 255));
    if (idx < 16 || r < 15) begin
      r = $urandom_range(0, 99);
      if (r < 8) len = '0;
      else if (r < 70) len = 6'($urandom_range(1, 12));
      else if (r < 90) len = 6'($urandom_range(13, 32));
      else len = 6'($urandom_range(33, 63));
      if (len != 0) hot_syms = {hot_syms, sym};
      if (hot_syms.size() > 24) void'(hot_syms.pop_front());
      send_word(hte_pkg::OP_LOAD, sym, len, $urandom());
    end else if (r < 85) begin
      if (hot_syms.size() != 0 && $urandom_range(0, 3) != 0)
        sym = hot_syms[$urandom_range(0, hot_syms.size() - 1)];
      send_word(hte_pkg::OP_ENCODE, sym, 6'($urandom()), $urandom());
    end else if (r < 95) begin
      send_word(hte_pkg::OP_FLUSH, sym, 6'($urandom()), $urandom());
    end else begin
      send_word(OP_UNUSED, sym, 6'($urandom()), $urandom());
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= hte_pkg::OP_LOAD;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty entries, the longest code, overlong lengths, dropped high bits,
    // exact byte fills, flush with and without waiting bits, and the unused opcode.
    send_word(hte_pkg::OP_LOAD,   8'h00, 6'd0,  32'hFFFF_FFFF);
    send_word(hte_pkg::OP_LOAD,   8'hFF, 6'd32, 32'hFFFF_FFFF);
    send_word(hte_pkg::OP_LOAD,   8'h01, 6'd1,  32'h0000_0001);
    send_word(hte_pkg::OP_LOAD,   8'h02, 6'd63, 32'hA5C3_0F96);
    send_word(hte_pkg::OP_LOAD,   8'h03, 6'd7,  32'hFFFF_FF2A);
    send_word(hte_pkg::OP_LOAD,   8'h80, 6'd8,  32'h0000_00C3);
    send_word(hte_pkg::OP_LOAD,   8'h55, 6'd33, 32'h0123_4567);
    send_word(hte_pkg::OP_ENCODE, 8'h01, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'hFF, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'h00, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'hAA, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'h02, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'h03, 6'd0,  32'h0);
    send_word(hte_pkg::OP_FLUSH,  8'h00, 6'd0,  32'h0);
    send_word(hte_pkg::OP_FLUSH,  8'hFF, 6'd63, 32'hFFFF_FFFF);
    send_word(OP_UNUSED,          8'h7F, 6'd42, 32'h5555_5555);
    send_word(hte_pkg::OP_ENCODE, 8'h80, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'h03, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'hFF, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'h55, 6'd0,  32'h0);
    send_word(hte_pkg::OP_FLUSH,  8'h00, 6'd0,  32'h0);
    send_word(hte_pkg::OP_LOAD,   8'h01, 6'd0,  32'h0000_0001);
    send_word(hte_pkg::OP_ENCODE, 8'h01, 6'd0,  32'h0);
    send_word(hte_pkg::OP_ENCODE, 8'h03, 6'd0,  32'h0);
    send_word(hte_pkg::OP_FLUSH,  8'h00, 6'd0,  32'h0);

    for (int i = 0; i < RANDOM_N; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random_word(i);
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS huffman_table_encoder_core");
    end else begin
      $display("FAIL huffman_table_encoder_core");
    end
    $finish;
  end

  // Worst case is far below this: every word stalled by long gaps on both sides.
  initial begin
    #5_000_000;
    $display("FAIL huffman_table_encoder_core");
    $finish;
  end

endmodule
